### src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SDTQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

`define SDTQ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define SDTQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define SDTQ_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### src/sdtq_pkg.sv
package sdtq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TAG_BITS_DEF    = 16;
	localparam int TIME_BITS_DEF   = 48;

	localparam int MAX_PER_TICK = 16;
	localparam int DELAY_W      = 32;
	localparam int TAG_W        = 16;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_ZERO     = 2'd2,
		ST_EXPIRED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_TICK
	} state_t;

	typedef struct packed {
		logic accept;
		logic add_done;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic head_due;
		logic last_pop;
		logic out_free;
	} sts_t;

endpackage

### src/sdtq_ctrl.sv
module sdtq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          opcode,
	input  sdtq_pkg::sts_t sts,
	output sdtq_pkg::cmd_t cmd
);

	sdtq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdtq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.add_done = 1'b0;
		cmd.pop      = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			sdtq_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = (opcode == sdtq_pkg::OP_TICK) ? sdtq_pkg::S_TICK
						: sdtq_pkg::S_ADD;
				end
			end
			sdtq_pkg::S_ADD: begin
				if (sts.out_free) begin
					cmd.add_done = 1'b1;
					state_d      = sdtq_pkg::S_IDLE;
				end
			end
			sdtq_pkg::S_TICK: begin
				// drain due entries from the head, one per cycle while the output register is free
				if (!sts.head_due) begin
					state_d = sdtq_pkg::S_IDLE;
				end else if (sts.out_free) begin
					cmd.pop = 1'b1;
					if (sts.last_pop) begin
						state_d = sdtq_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = sdtq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### src/sdtq_datapath.sv
module sdtq_datapath #(
	parameter int QUEUE_DEPTH = sdtq_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = sdtq_pkg::TAG_BITS_DEF,
	parameter int TIME_BITS   = sdtq_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sdtq_pkg::cmd_t               cmd,
	output sdtq_pkg::sts_t               sts,
	input  logic                         opcode,
	input  logic [sdtq_pkg::DELAY_W-1:0] delay_usec,
	input  logic [sdtq_pkg::TAG_W-1:0]   timer_tag,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [sdtq_pkg::TAG_W-1:0]   expired_tag,
	output logic                         last_of_run
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PC_W  = $clog2(sdtq_pkg::MAX_PER_TICK + 1);

	logic [TIME_BITS-1:0]        now_q;
	logic [TIME_BITS-1:0]        new_dl_q;
	logic                        zero_q;
	logic [sdtq_pkg::TAG_W-1:0]  tag_in_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [PC_W-1:0]             pc_q;
	logic [TIME_BITS-1:0]        dl_q [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]         tg_q [QUEUE_DEPTH];
	logic                        out_valid_q;
	sdtq_pkg::status_t           status_q;
	logic [sdtq_pkg::TAG_W-1:0]  tag_out_q;
	logic                        last_q;

	logic [QUEUE_DEPTH-1:0]      lt;
	logic [TIME_BITS-1:0]        ins_dl [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]         ins_tg [QUEUE_DEPTH];
	logic                        full;
	logic                        due0;
	logic                        due1;
	logic                        do_insert;
	logic                        is_tick;

	assign is_tick   = (opcode == sdtq_pkg::OP_TICK);
	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign do_insert = cmd.add_done && !zero_q && !full;
	assign due0      = (cnt_q != '0) && (dl_q[0] < now_q);
	assign due1      = (cnt_q > CNT_W'(1)) && (dl_q[1] < now_q);

	assign sts.head_due = due0;
	assign sts.last_pop = (pc_q == PC_W'(sdtq_pkg::MAX_PER_TICK - 1)) || !due1;
	assign sts.out_free = !out_valid_q || out_ready;

	// every cell compares against the new deadline; valid entries are a sorted prefix
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign lt[i] = (CNT_W'(i) < cnt_q) && (dl_q[i] < new_dl_q);
		if (i == 0) begin : g_head
			always_comb begin
				ins_dl[i] = lt[i] ? dl_q[i] : new_dl_q;
				ins_tg[i] = lt[i] ? tg_q[i] : TAG_BITS'(tag_in_q);
			end
		end else begin : g_body
			always_comb begin
				if (lt[i]) begin
					ins_dl[i] = dl_q[i];
					ins_tg[i] = tg_q[i];
				end else if (lt[i-1]) begin
					ins_dl[i] = new_dl_q;
					ins_tg[i] = TAG_BITS'(tag_in_q);
				end else begin
					ins_dl[i] = dl_q[i-1];
					ins_tg[i] = tg_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			cnt_q       <= '0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && is_tick) begin
				now_q <= now_q + TIME_BITS'(1);
			end
			if (cmd.accept) begin
				pc_q <= '0;
			end else if (cmd.pop) begin
				pc_q <= pc_q + PC_W'(1);
			end
			if (do_insert) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.add_done || cmd.pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			new_dl_q <= now_q + TIME_BITS'(delay_usec);
			zero_q   <= (delay_usec == '0);
			tag_in_q <= timer_tag;
		end
		if (do_insert) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				dl_q[i] <= ins_dl[i];
				tg_q[i] <= ins_tg[i];
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				dl_q[i] <= dl_q[i+1];
				tg_q[i] <= tg_q[i+1];
			end
		end
		if (cmd.add_done) begin
			priority if (zero_q) begin
				status_q <= sdtq_pkg::ST_ZERO;
			end else if (full) begin
				status_q <= sdtq_pkg::ST_FULL;
			end else begin
				status_q <= sdtq_pkg::ST_ACCEPTED;
			end
			tag_out_q <= tag_in_q;
			last_q    <= 1'b1;
		end else if (cmd.pop) begin
			status_q  <= sdtq_pkg::ST_EXPIRED;
			tag_out_q <= sdtq_pkg::TAG_W'(tg_q[0]);
			last_q    <= sts.last_pop;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign expired_tag = tag_out_q;
	assign last_of_run = last_q;

endmodule

### src/sorted_deadline_timer_queue.sv
// sorted deadline timer queue
// input channel (in_valid/in_ready): one request per item, opcode add or tick.
//   add: delay_usec and timer_tag; deadline is the current microsecond count
//   plus the delay. tick: advances the count by one and expires due timers.
// output channel (out_valid/out_ready): status, expired_tag, last_of_run.
//   an add gives exactly one result; a tick gives zero to sixteen expiries,
//   earliest first, the final one marked with last_of_run.
// sequence: an add result is written to the output register from the add
//   state; a tick writes its first expiry from the tick state and the rest
//   after it. a tick with nothing due returns to idle without a result.
// throughput: one item at a time; the head-pop sequencer pops one entry a
//   cycle while the output register is free.
// the queue is a row of registers; an insert compares all cells at once and
//   shifts the later ones up, a pop shifts everything down.
// reset clears the time count, the entry count, the pop count and the output valid flag.
// when the receiver stalls, the result is held in the output register and the
//   sequencer waits; the next request is taken only after the current item.
`include "assert_macros.svh"

module sorted_deadline_timer_queue #(
	parameter int QUEUE_DEPTH = sdtq_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = sdtq_pkg::TAG_BITS_DEF,
	parameter int TIME_BITS   = sdtq_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [sdtq_pkg::DELAY_W-1:0] delay_usec,
	input  logic [sdtq_pkg::TAG_W-1:0]   timer_tag,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [sdtq_pkg::TAG_W-1:0]   expired_tag,
	output logic                         last_of_run
);

	sdtq_pkg::cmd_t cmd;
	sdtq_pkg::sts_t sts;

	sdtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	sdtq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (opcode),
		.delay_usec  (delay_usec),
		.timer_tag   (timer_tag),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.expired_tag (expired_tag),
		.last_of_run (last_of_run)
	);

	`SDTQ_ASSERT_IMPL(a_pop_needs_due, clk, arst_n, cmd.pop, sts.head_due)
	`SDTQ_ASSERT_IMPL(a_write_needs_room, clk, arst_n, cmd.pop || cmd.add_done, sts.out_free)
	`SDTQ_ASSERT_NEVER(a_accept_while_busy, clk, arst_n, cmd.accept && (cmd.pop || cmd.add_done))
	`SDTQ_ASSERT_IMPL(a_result_follows_cmd, clk, arst_n, cmd.pop || cmd.add_done, ##1 out_valid)

endmodule
